// ===== rtl/core/plevl_pkg.sv =====
package plevl_pkg;

    // Sample format: two's complement Q3.20
    localparam int SAMPLE_W  = 24;
    localparam int THRESH_W  = 21;
    localparam int PASS_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int SEG_COUNT = 6;
    localparam int SEG_W     = 3;
    localparam int QUOT_W    = 18;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS     = 2'd2;

    // Register reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET     = 21'd1048;
    localparam logic [PASS_W-1:0]   PASS_COUNT_RESET = 3'd2;

    // Saturation limits and the above-full-scale answer (+0.99)
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX     = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN     = -24'sh800000;
    localparam logic signed [SAMPLE_W-1:0] NEARLY_ONE  = 24'sd1038090;

    // Segment upper limits; entry one is replaced by the noise threshold
    localparam logic [THRESH_W-1:0] SEG_LIMIT [SEG_COUNT] = '{
        21'd105, 21'd0, 21'd104858, 21'd314573, 21'd524288, 21'd1048576
    };

    // Offset chain constants in fifths of an LSB, before the threshold is taken off
    localparam logic signed [22:0] OFF5_LOW  = -23'sd105;
    localparam logic signed [22:0] OFF5_MID  = 23'sd314468;
    localparam logic signed [22:0] OFF5_HIGH = 23'sd838756;

    // Reciprocal of five, scaled by 2^25
    localparam logic [22:0] RECIP5 = 23'd6710887;

    typedef enum logic [1:0] {
        GAIN_FOUR_FIFTHS,
        GAIN_UNITY,
        GAIN_SIX_FIFTHS
    } t_gain;

    localparam t_gain SEG_GAIN [SEG_COUNT] = '{
        GAIN_FOUR_FIFTHS, GAIN_UNITY, GAIN_SIX_FIFTHS,
        GAIN_SIX_FIFTHS, GAIN_UNITY, GAIN_FOUR_FIFTHS
    };

    typedef logic [SEG_COUNT-1:0][SAMPLE_W-1:0] t_off_arr;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       last_in;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last_out;
    } t_out;

    // Sample as it moves between passes
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic                       last;
    } t_smp;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [PASS_W-1:0]   pass_count;
        logic                bypass;
        t_off_arr            offsets;
    } t_cfg;

    // Floor of u/5, exact for u below 2^23
    function automatic logic [20:0] div5_floor(input logic [22:0] u);
        logic [45:0] prod;
        prod = 46'(u) * 46'(RECIP5);
        return prod[45:25];
    endfunction

    // Signed value divided by five, rounded to nearest
    function automatic logic signed [SAMPLE_W-1:0] round5_signed(input logic signed [22:0] v);
        logic [21:0] a;
        logic [20:0] r;
        a = v[22] ? 22'($unsigned(-v)) : 22'($unsigned(v));
        r = div5_floor(23'(a) + 23'd2);
        return v[22] ? -$signed({3'b000, r}) : $signed({3'b000, r});
    endfunction

    // Chain the segment offsets so that the curve stays continuous
    function automatic t_off_arr offsets_for(input logic [THRESH_W-1:0] t);
        logic signed [22:0] tt;
        t_off_arr           o;
        tt   = $signed({2'b00, t});
        o[0] = '0;
        o[1] = round5_signed(OFF5_LOW);
        o[2] = round5_signed(OFF5_LOW - tt);
        o[3] = o[2];
        o[4] = round5_signed(OFF5_MID - tt);
        o[5] = round5_signed(OFF5_HIGH - tt);
        return o;
    endfunction

endpackage

// ===== rtl/core/plevl_cfg.sv =====
module plevl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [plevl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [plevl_pkg::THRESH_W-1:0]  i_cfg_wdata,
    output plevl_pkg::t_cfg                o_cfg
);
    import plevl_pkg::*;

    logic [THRESH_W-1:0] r_threshold;
    logic [PASS_W-1:0]   r_pass_count;
    logic                r_bypass;
    t_off_arr            r_offsets;

    // Write registers; offsets follow the threshold in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESH_RESET;
            r_pass_count <= PASS_COUNT_RESET;
            r_bypass     <= 1'b0;
            r_offsets    <= offsets_for(THRESH_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: begin
                    r_threshold <= i_cfg_wdata;
                    r_offsets   <= offsets_for(i_cfg_wdata);
                end
                REG_PASS_COUNT: r_pass_count <= i_cfg_wdata[PASS_W-1:0];
                REG_BYPASS:     r_bypass     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.threshold  = r_threshold;
    assign o_cfg.pass_count = r_pass_count;
    assign o_cfg.bypass     = r_bypass;
    assign o_cfg.offsets    = r_offsets;

endmodule

// ===== rtl/core/plevl_pass.sv =====
module plevl_pass (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  plevl_pkg::t_cfg i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  plevl_pkg::t_smp i_smp,
    output logic            o_valid,
    input  logic            i_ready,
    output plevl_pkg::t_smp o_smp
);
    import plevl_pkg::*;

    // Stage one: magnitude and segment choice
    logic                r1_v;
    logic                r1_en;
    t_smp                r1_smp;
    logic                r1_neg;
    logic                r1_over;
    logic [SEG_W-1:0]    r1_seg;
    logic [SAMPLE_W-1:0] r1_mag;

    // Stage two: rounded fifth of the magnitude
    logic                r2_v;
    logic                r2_en;
    t_smp                r2_smp;
    logic                r2_neg;
    logic                r2_over;
    logic [SEG_W-1:0]    r2_seg;
    logic [SAMPLE_W-1:0] r2_mag;
    logic [QUOT_W-1:0]   r2_q;

    // Stage three: curve result
    logic r3_v;
    t_smp r3_smp;

    logic rdy1, rdy2, rdy3;
    assign rdy3    = !r3_v || i_ready;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    logic                n_neg;
    logic [SAMPLE_W-1:0] n_mag;
    logic [SEG_W-1:0]    n_seg;
    logic                n_hit;
    logic [THRESH_W-1:0] lim;

    // Pick the first segment whose limit covers the magnitude
    always_comb begin
        n_neg = i_smp.x[SAMPLE_W-1];
        n_mag = n_neg ? $unsigned(-i_smp.x) : $unsigned(i_smp.x);
        n_seg = '0;
        n_hit = 1'b0;
        lim   = '0;
        for (int f = SEG_COUNT - 1; f >= 0; f--) begin
            lim = (f == 1) ? i_cfg.threshold : SEG_LIMIT[f];
            if (n_mag <= SAMPLE_W'(lim)) begin
                n_seg = SEG_W'(f);
                n_hit = 1'b1;
            end
        end
    end

    logic [20:0]       quot;
    logic [QUOT_W-1:0] n_q;

    // Segments with a fractional gain stay at or below 1.0, so 21 bits suffice
    always_comb begin
        quot = div5_floor(23'(r1_mag[20:0]) + 23'd2);
        n_q  = quot[QUOT_W-1:0];
    end

    logic signed [SAMPLE_W+1:0] mag_s, q_s, off_s, base, m, y;
    logic signed [SAMPLE_W-1:0] sat;
    t_smp                       n_smp;

    // Apply gain and offset, restore sign, saturate; a disabled pass forwards the sample and an overload gives +0.99
    always_comb begin
        mag_s = $signed({2'b00, r2_mag});
        q_s   = $signed({{(SAMPLE_W + 2 - QUOT_W){1'b0}}, r2_q});
        off_s = (SAMPLE_W + 2)'($signed(i_cfg.offsets[r2_seg]));
        case (SEG_GAIN[r2_seg])
            GAIN_FOUR_FIFTHS: base = mag_s - q_s;
            GAIN_SIX_FIFTHS:  base = mag_s + q_s;
            default:          base = mag_s;
        endcase
        m = base + off_s;
        y = r2_neg ? -m : m;
        if (y > (SAMPLE_W + 2)'(SMP_MAX)) begin
            sat = SMP_MAX;
        end else if (y < (SAMPLE_W + 2)'(SMP_MIN)) begin
            sat = SMP_MIN;
        end else begin
            sat = y[SAMPLE_W-1:0];
        end
        n_smp.last = r2_smp.last;
        if (!r2_en) begin
            n_smp.x = r2_smp.x;
        end else if (r2_over) begin
            n_smp.x = NEARLY_ONE;
        end else begin
            n_smp.x = sat;
        end
    end

    // Advance valid bits where the next stage has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    // Move payload with the valid bits
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_en   <= i_en;
            r1_smp  <= i_smp;
            r1_neg  <= n_neg;
            r1_over <= !n_hit;
            r1_seg  <= n_seg;
            r1_mag  <= n_mag;
        end
        if (rdy2 && r1_v) begin
            r2_en   <= r1_en;
            r2_smp  <= r1_smp;
            r2_neg  <= r1_neg;
            r2_over <= r1_over;
            r2_seg  <= r1_seg;
            r2_mag  <= r1_mag;
            r2_q    <= n_q;
        end
        if (rdy3 && r2_v) begin
            r3_smp <= n_smp;
        end
    end

    assign o_valid = r3_v;
    assign o_smp   = r3_smp;

endmodule

// ===== rtl/core/piecewise_linear_leveller.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in  (sample_in, last_in)
// output    out        o_out_valid / i_out_ready o_out (sample_out, last_out)
// config    in         i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// One item per cycle while the output is not stalled; each item passes through the
// three-stage pass unit, repeated once for each pass, from acceptance to output.
// Passes beyond the pass count (or all, in bypass) forward the sample untouched.
// Reset is synchronous; there is no clearing pass.
// A stalled output holds its item; each stage holds only when the next is full
// and stalled, so bubbles close up and nothing is lost or repeated.
module piecewise_linear_leveller #(
    parameter int MAX_PASSES = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  plevl_pkg::t_in                  i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output plevl_pkg::t_out                 o_out,
    input  logic                            i_cfg_we,
    input  logic [plevl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [plevl_pkg::THRESH_W-1:0]  i_cfg_wdata
);
    import plevl_pkg::*;

    localparam int CNT_W = $clog2(MAX_PASSES + 1) > PASS_W ?
                           $clog2(MAX_PASSES + 1) : PASS_W;

    t_cfg cfg;

    plevl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Limit the pass count and enable the leading passes
    logic [CNT_W-1:0]      eff_count;
    logic [MAX_PASSES-1:0] pass_en;

    always_comb begin
        if (CNT_W'(cfg.pass_count) > CNT_W'(MAX_PASSES)) begin
            eff_count = CNT_W'(MAX_PASSES);
        end else begin
            eff_count = CNT_W'(cfg.pass_count);
        end
        for (int p = 0; p < MAX_PASSES; p++) begin
            pass_en[p] = !cfg.bypass && (CNT_W'(p) < eff_count);
        end
    end

    logic [MAX_PASSES:0] v;
    logic [MAX_PASSES:0] rdy;
    t_smp                smp [MAX_PASSES+1];

    assign v[0]        = i_in_valid;
    assign o_in_ready  = rdy[0];
    assign smp[0].x    = i_in.sample_in;
    assign smp[0].last = i_in.last_in;

    // One pass unit for each possible pass
    for (genvar p = 0; p < MAX_PASSES; p++) begin : g_pass
        plevl_pass u_pass (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pass_en[p]),
            .i_cfg   (cfg),
            .i_valid (v[p]),
            .o_ready (rdy[p]),
            .i_smp   (smp[p]),
            .o_valid (v[p+1]),
            .i_ready (rdy[p+1]),
            .o_smp   (smp[p+1])
        );
    end

    assign rdy[MAX_PASSES] = i_out_ready;
    assign o_out_valid     = v[MAX_PASSES];
    assign o_out.sample_out = smp[MAX_PASSES].x;
    assign o_out.last_out   = smp[MAX_PASSES].last;

endmodule

// ===== rtl/core/plevl_checker.sv =====
module plevl_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input plevl_pkg::t_out o_out
);
    import plevl_pkg::*;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled item holds at the output
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled output item changed");

    // A free output never back-pressures the input
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output free");

    // Input stalls only when the output holds an item it cannot pass on
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

endmodule

bind piecewise_linear_leveller plevl_checker u_plevl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plevl_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int LEVEL_PASSES = 5;
    localparam int LATENCY      = 3 * LEVEL_PASSES;
    localparam int LONG_HOLD    = 120;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 20;

    // Index past the end of the register list; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [THRESH_W-1:0]  wdata;
        t_in                  smp;
        logic                 typed;
        t_out                 want;
    } t_row;

    localparam int DIRECTED_ROWS = 32;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in                  i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out                 o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [THRESH_W-1:0]  i_cfg_wdata;

    // Shadow of the register file and the derived segment offsets
    logic [THRESH_W-1:0]        thr_shadow;
    logic [PASS_W-1:0]          passes_shadow;
    logic                       bypass_shadow;
    logic signed [SAMPLE_W-1:0] knee_offset [SEG_COUNT];

    t_out levelled_due [$];

    int  fault_count      = 0;
    int  samples_sent     = 0;
    int  samples_checked  = 0;
    int  settings_applied = 0;
    int  cycle_count      = 0;
    int  gap_left         = 0;
    bit  tx_idle_on       = 1'b1;
    bit  rx_idle_on       = 1'b1;
    bit  quiet            = 1'b0;
    bit  long_hold_req    = 1'b0;

    // Directed items; a typed expectation is used where the answer is obvious
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, '0, '0, '{24'sd0, 1'b0}, 1'b1, '{24'sd0, 1'b0}},
        '{ROW_SAMPLE, '0, '0, '{SMP_MAX, 1'b1}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{SMP_MIN, 1'b0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{24'sd105, 1'b0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{-24'sd106, 1'b1}, 1'b0, '0},
        '{ROW_WRITE, REG_PASS_COUNT, 21'd1, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{24'sd2000000, 1'b0}, 1'b1, '{NEARLY_ONE, 1'b0}},
        '{ROW_SAMPLE, '0, '0, '{-24'sd2000000, 1'b1}, 1'b1, '{NEARLY_ONE, 1'b1}},
        '{ROW_SAMPLE, '0, '0, '{24'sd1048576, 1'b0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{-24'sd1048577, 1'b0}, 1'b1, '{NEARLY_ONE, 1'b0}},
        '{ROW_SAMPLE, '0, '0, '{-24'sd1, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_BYPASS, 21'h155555, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{SMP_MIN, 1'b0}, 1'b1, '{SMP_MIN, 1'b0}},
        '{ROW_SAMPLE, '0, '0, '{SMP_MAX, 1'b1}, 1'b1, '{SMP_MAX, 1'b1}},
        '{ROW_WRITE, REG_BYPASS, 21'h0AAAAA, '0, 1'b0, '0},
        '{ROW_WRITE, REG_PASS_COUNT, 21'h1FFFF8, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{24'sd123456, 1'b0}, 1'b1, '{24'sd123456, 1'b0}},
        '{ROW_SAMPLE, '0, '0, '{-24'sd777, 1'b1}, 1'b1, '{-24'sd777, 1'b1}},
        '{ROW_WRITE, REG_PASS_COUNT, 21'd7, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{24'sd300000, 1'b0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{-24'sd700000, 1'b1}, 1'b0, '0},
        '{ROW_WRITE, REG_THRESHOLD, 21'd0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{24'sd50, 1'b0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{-24'sd500, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_THRESHOLD, 21'h1FFFFF, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{24'sd1500000, 1'b0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{SMP_MIN, 1'b1}, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE, 21'h000007, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{24'sd2097151, 1'b0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{-24'sd2097152, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_THRESHOLD, 21'd104858, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{24'sd104858, 1'b1}, 1'b0, '0}
    };

    piecewise_linear_leveller #(
        .MAX_PASSES(LEVEL_PASSES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Gain of a segment in fifths
    function automatic longint gain5(input int f);
        case (SEG_GAIN[f])
            GAIN_FOUR_FIFTHS: return 4;
            GAIN_SIX_FIFTHS:  return 6;
            default:          return 5;
        endcase
    endfunction

    // Upper magnitude limit of a segment; the second one is the noise threshold
    function automatic longint knee(input int f);
        return (f == 1) ? longint'(thr_shadow) : longint'(SEG_LIMIT[f]);
    endfunction

    function automatic longint div5_nearest(input longint v);
        if (v >= 0) return (v + 2) / 5;
        return -((-v + 2) / 5);
    endfunction

    function automatic longint clamp_sample(input longint v);
        if (v > longint'(SMP_MAX)) return longint'(SMP_MAX);
        if (v < longint'(SMP_MIN)) return longint'(SMP_MIN);
        return v;
    endfunction

    // Chain the offsets in fifths of an LSB so that the curve stays continuous
    function automatic void rebuild_offsets();
        longint carried;
        longint off5;
        carried = gain5(0) * knee(0);
        knee_offset[0] = '0;
        for (int f = 1; f < SEG_COUNT; f++) begin
            off5 = carried - gain5(f) * knee(f - 1);
            knee_offset[f] = SAMPLE_W'(clamp_sample(div5_nearest(off5)));
            carried = gain5(f) * knee(f) + off5;
        end
    endfunction

    // One trip through the magnitude curve
    function automatic longint curve_once(input longint x);
        longint mag;
        longint m;
        mag = (x < 0) ? -x : x;
        for (int f = 0; f < SEG_COUNT; f++) begin
            if (mag <= knee(f)) begin
                m = div5_nearest(gain5(f) * mag + 5 * longint'(knee_offset[f]));
                return clamp_sample((x < 0) ? -m : m);
            end
        end
        // above full scale: always +0.99, whatever the sign
        return longint'(NEARLY_ONE);
    endfunction

    function automatic t_out level_sample(input t_in s);
        longint x;
        int     n;
        t_out   r;
        x = longint'(s.sample_in);
        n = (passes_shadow > LEVEL_PASSES) ? LEVEL_PASSES : int'(passes_shadow);
        if (!bypass_shadow) begin
            for (int p = 0; p < n; p++) x = curve_once(x);
        end
        r.sample_out = x[SAMPLE_W-1:0];
        r.last_out   = s.last_in;
        return r;
    endfunction

    function automatic logic [THRESH_W-1:0] pick_threshold(input int mode);
        case (mode)
            0:       return '0;
            1:       return '1;
            2:       return THRESH_RESET;
            3:       return 21'd1048576;
            4:       return 21'd105;
            5:       return THRESH_W'($urandom_range(0, 2000));
            default: return THRESH_W'($urandom);
        endcase
    endfunction

    // Mix of full-range codes, small levels, segment edges and overloads
    function automatic t_in next_sample();
        t_in    s;
        longint v;
        int     f;
        f = $urandom_range(0, SEG_COUNT - 1);
        case ($urandom_range(0, 9))
            0, 1, 2: v = longint'($signed(SAMPLE_W'($urandom)));
            3, 4:    v = $urandom_range(0, 2000);
            5, 6:    v = knee(f) + int'($urandom_range(0, 6)) - 3;
            7:       v = $urandom_range(0, 1100000);
            8: begin
                case ($urandom_range(0, 3))
                    0:       v = longint'(SMP_MAX);
                    1:       v = longint'(SMP_MIN);
                    2:       v = 0;
                    default: v = 1;
                endcase
            end
            default: v = $urandom_range(1048577, 8388607);
        endcase
        if ($urandom_range(0, 1) == 1) v = -v;
        s.sample_in = v[SAMPLE_W-1:0];
        s.last_in   = ($urandom_range(0, 7) == 0);
        return s;
    endfunction

    // Write one register and keep the shadow in step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [THRESH_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_THRESHOLD: begin
                thr_shadow = data;
                rebuild_offsets();
            end
            REG_PASS_COUNT: passes_shadow = data[PASS_W-1:0];
            REG_BYPASS:     bypass_shadow = data[0];
            default: ;
        endcase
        settings_applied++;
        @(posedge i_clk);
    endtask

    // Hold the input off until every pending item has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (levelled_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        if (tx_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Offer one item and record what it should come back as
    task automatic offer(input t_in s, input logic typed, input t_out want);
        i_in       <= s;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        levelled_due.push_back(typed ? want : level_sample(s));
        samples_sent++;
    endtask

    // Check results and pace the ready line
    always @(posedge i_clk) begin : rx_check
        t_out due;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            gap_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (levelled_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("%0t: unexpected item sample_out=%0d last_out=%0b",
                                 $time, o_out.sample_out, o_out.last_out);
                end else begin
                    due = levelled_due.pop_front();
                    samples_checked++;
                    if (o_out.sample_out !== due.sample_out) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display("%0t: sample_out expected %0d, actual %0d",
                                     $time, due.sample_out, o_out.sample_out);
                    end
                    if (o_out.last_out !== due.last_out) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display("%0t: last_out expected %0b, actual %0b",
                                     $time, due.last_out, o_out.last_out);
                    end
                end
            end
            if (long_hold_req) begin
                gap_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (rx_idle_on && !quiet && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 18);
            end
            i_out_ready <= (gap_left == 0);
        end
    end

    // Give up if the run hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d items outstanding", $time, levelled_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_out                none;
        logic [THRESH_W-1:0] data;
        none = '0;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_wdata <= '0;

        thr_shadow    = THRESH_RESET;
        passes_shadow = PASS_COUNT_RESET;
        bypass_shadow = 1'b0;
        rebuild_offsets();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                drain();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].wdata);
            end else begin
                i_cfg_we <= 1'b0;
                idle_gap();
                offer(directed_rows[r].smp, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, THRESH_W'($urandom));
            write_reg(REG_THRESHOLD, pick_threshold((ph < 7) ? ph : $urandom_range(0, 7)));
            data = THRESH_W'($urandom);
            data[PASS_W-1:0] = (ph < 8) ? PASS_W'(ph) : PASS_W'($urandom_range(0, 7));
            write_reg(REG_PASS_COUNT, data);
            data = THRESH_W'($urandom);
            data[0] = (ph == 5) || (ph < PHASES - 1 && $urandom_range(0, 7) == 0);
            write_reg(REG_BYPASS, data);
            i_cfg_we <= 1'b0;

            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            quiet      = (ph == PHASES - 1);
            // flood the input while the output is held off
            if (ph == 2) begin
                tx_idle_on    = 1'b0;
                long_hold_req = 1'b1;
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                idle_gap();
                offer(next_sample(), 1'b0, none);
            end
        end

        drain();
        repeat (2 * LATENCY + 10) @(posedge i_clk);

        $display("Levelled %0d samples over %0d register writes, %0d results checked",
                 samples_sent, settings_applied, samples_checked);
        $display("Covered bypass, zero to seven passes, thresholds from zero to full code");
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
